// ===== hdl/rfe_pkg.sv =====
// Shared types and constants for the rotated frame store fill engine.
// No dependencies; every other file imports this package.
package rfe_pkg;

	localparam int KIND_W  = 2;
	localparam int POS_W   = 8;
	localparam int EXT_W   = 8;
	localparam int WORD_W  = 16;
	localparam int ORIENT_W = 2;

	// signed rectangle bounds: frame edges up to 1024 plus 8-bit offsets and extents
	localparam int COORD_W = 12;
	// physical column/row and word address, sized for the largest frame (1024 x 1024)
	localparam int PIX_W   = 10;
	localparam int ADDR_W  = 20;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_DRAW  = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [ORIENT_W-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} orient_t;

	typedef enum logic {
		REG_ORIENTATION = 1'b0,
		REG_AUTO_CLEAR  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_FILL = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_FILL = 2'd1,
		BK_READ = 2'd2
	} back_state_t;

	// one queued job for the back end: a clipped physical rectangle
	typedef struct packed {
		op_t               op;
		logic              zero;     // read outside the frame: answer 0
		logic [PIX_W-1:0]  sx;
		logic [PIX_W-1:0]  ex;
		logic [PIX_W-1:0]  sy;
		logic [PIX_W-1:0]  ey;
		logic [ADDR_W-1:0] row_base; // sy * frame width
		logic [WORD_W-1:0] word;
	} rfe_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] c);
		return {c[7:0], c[15:8]};
	endfunction

endpackage

// ===== hdl/rfe_chan_if.sv =====
// Valid/ready channel interfaces: commands in, read results out.
// Depends on rfe_pkg for field widths.
interface rfe_cmd_if import rfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [EXT_W-1:0]  extent_x;
	logic [EXT_W-1:0]  extent_y;
	logic [WORD_W-1:0] color;

	modport source(output valid, kind, pos_x, pos_y, extent_x, extent_y, color, input ready);
	modport sink(input valid, kind, pos_x, pos_y, extent_x, extent_y, color, output ready);
endinterface

interface rfe_pix_if import rfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] pixel_word;

	modport source(output valid, pixel_word, input ready);
	modport sink(input valid, pixel_word, output ready);
endinterface

// ===== hdl/rotated_framebuffer_fill_engine.sv =====
// Top level of the rotated frame store fill engine.
// Depends on rfe_pkg, rfe_chan_if, rfe_front, rfe_cmd_fifo and rfe_back.

// Holds a FRAME_WIDTH x FRAME_HEIGHT store of 16-bit words (row-major) and
// runs draw, fill, clear and read commands given in logical coordinates,
// rotated by the orientation register. Written colors are byte-swapped;
// reads return the stored word, or 0 outside the frame. After reset the
// store is zeroed by a sweep over all FRAME_WIDTH*FRAME_HEIGHT words during
// which cmd.ready stays low. The single-port frame store serializes the work:
// a draw writes or a read fetches one word, a fill writes each clipped pixel
// in turn and a clear sweeps the whole store; empty fills and suppressed
// clears take no store time. A command passes the front-end stages
// (mapping/clipping, then the row-address multiply) before a 4-deep job
// queue. Configuration writes must only happen while the engine is idle.
module rotated_framebuffer_fill_engine import rfe_pkg::*; #(
	parameter int FRAME_WIDTH  = 240,
	parameter int FRAME_HEIGHT = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [ORIENT_W-1:0] cfg_data,
	rfe_cmd_if.sink             cmd,
	rfe_pix_if.source           pix
);

	logic [ORIENT_W-1:0] orientation_q;
	logic                auto_clear_q;

	logic       push, pop, init_busy;
	rfe_cmd_t   push_cmd, head;
	fifo_stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q <= ROT_0;
			auto_clear_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIENTATION: orientation_q <= cfg_data;
				REG_AUTO_CLEAR:  auto_clear_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front end: rotation, clipping, row base
	rfe_front #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.orientation(orientation_q),
		.auto_clear (auto_clear_q),
		.hold       (init_busy),
		.stat       (stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// job queue decouples the front end from the store sweep
	rfe_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	// back end: frame store and sweep sequencer
	rfe_back #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (stat),
		.pop      (pop),
		.init_busy(init_busy),
		.pix      (pix)
	);

endmodule

// ===== hdl/rfe_front.sv =====
// Front end: accepts commands, maps them through the rotation, clips to the frame
// and computes the row base address. Depends on rfe_pkg and rfe_cmd_if.
module rfe_front import rfe_pkg::*; #(
	parameter int FRAME_WIDTH  = 240,
	parameter int FRAME_HEIGHT = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	rfe_cmd_if.sink             cmd,
	input  logic [ORIENT_W-1:0] orientation,
	input  logic                auto_clear,
	input  logic                hold,
	input  fifo_stat_t          stat,
	output logic                push,
	output rfe_cmd_t            push_cmd
);

	localparam logic signed [COORD_W-1:0] WS  = COORD_W'(FRAME_WIDTH);
	localparam logic signed [COORD_W-1:0] HS  = COORD_W'(FRAME_HEIGHT);
	localparam logic signed [COORD_W-1:0] WM1 = COORD_W'(FRAME_WIDTH - 1);
	localparam logic signed [COORD_W-1:0] HM1 = COORD_W'(FRAME_HEIGHT - 1);
	localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);
	localparam logic signed [COORD_W-1:0] ZRO = COORD_W'(0);

	logic signed [COORD_W-1:0] x, y, cx, cy;
	logic signed [COORD_W-1:0] sx, ex, sy, ey;
	logic signed [COORD_W-1:0] sx_c, ex_c, sy_c, ey_c;
	kind_t                     kind;
	logic                      adv1, adv2;

	logic                      valid_s1;
	logic signed [COORD_W-1:0] sx_s1, ex_s1, sy_s1, ey_s1;
	op_t                       op_s1;
	logic                      drop_s1;
	logic [WORD_W-1:0]         word_s1;

	logic                      empty;
	logic                      valid_s2;
	rfe_cmd_t                  cmd_s2;

	always_comb begin
		kind = kind_t'(cmd.kind);
		x    = $signed({{(COORD_W-POS_W){1'b0}}, cmd.pos_x});
		y    = $signed({{(COORD_W-POS_W){1'b0}}, cmd.pos_y});
		if (kind == KIND_FILL) begin
			cx = $signed({{(COORD_W-EXT_W){1'b0}}, cmd.extent_x});
			cy = $signed({{(COORD_W-EXT_W){1'b0}}, cmd.extent_y});
		end else begin
			// a single pixel is a one-by-one rectangle
			cx = ONE;
			cy = ONE;
		end
		case (orient_t'(orientation))
			ROT_90: begin
				sx = y;            ex = y + cy - ONE;
				sy = HS - x - cx;  ey = HM1 - x;
			end
			ROT_180: begin
				sx = WS - x - cx;  ex = WM1 - x;
				sy = HS - y - cy;  ey = HM1 - y;
			end
			ROT_270: begin
				sx = WS - y - cy;  ex = WM1 - y;
				sy = x;            ey = x + cx - ONE;
			end
			default: begin
				sx = x;            ex = x + cx - ONE;
				sy = y;            ey = y + cy - ONE;
			end
		endcase
		if (kind == KIND_CLEAR) begin
			sx = ZRO; ex = WM1;
			sy = ZRO; ey = HM1;
		end
		sx_c = (sx < ZRO) ? ZRO : sx;
		sy_c = (sy < ZRO) ? ZRO : sy;
		ex_c = (ex > WM1) ? WM1 : ex;
		ey_c = (ey > HM1) ? HM1 : ey;
	end

	assign push = valid_s2 && !stat.full;
	assign push_cmd = cmd_s2;
	assign adv2 = !valid_s2 || !stat.full;
	assign adv1 = !valid_s1 || adv2;
	assign cmd.ready = adv1 && !hold;

	// stage 1: mapped and clipped bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= cmd.valid && cmd.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sx_s1   <= sx_c;
			ex_s1   <= ex_c;
			sy_s1   <= sy_c;
			ey_s1   <= ey_c;
			op_s1   <= (kind == KIND_READ) ? OP_READ : OP_FILL;
			drop_s1 <= (kind == KIND_CLEAR) && auto_clear;
			word_s1 <= swap_bytes(cmd.color);
		end
	end

	// stage 2: emptiness and row base; empty writes and suppressed clears are dropped here
	assign empty = (sx_s1 > ex_s1) || (sy_s1 > ey_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && !drop_s1 && ((op_s1 == OP_READ) || !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2.op       <= op_s1;
			cmd_s2.zero     <= empty;
			cmd_s2.sx       <= sx_s1[PIX_W-1:0];
			cmd_s2.ex       <= ex_s1[PIX_W-1:0];
			cmd_s2.sy       <= sy_s1[PIX_W-1:0];
			cmd_s2.ey       <= ey_s1[PIX_W-1:0];
			cmd_s2.row_base <= ADDR_W'(sy_s1[PIX_W-1:0]) * ADDR_W'(FRAME_WIDTH);
			cmd_s2.word     <= word_s1;
		end
	end

endmodule

// ===== hdl/rfe_cmd_fifo.sv =====
// Short job queue between front and back end.
// Depends on rfe_pkg for the job type and depth.
module rfe_cmd_fifo import rfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rfe_cmd_t   push_cmd,
	input  logic       pop,
	output rfe_cmd_t   head,
	output fifo_stat_t stat
);

	rfe_cmd_t             slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_AW:0]     count_q;

	assign head       = slot_q[rp_q];
	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/rfe_back.sv =====
// Back end: frame store, rectangle sweep sequencer and read result register.
// Depends on rfe_pkg and rfe_pix_if.
module rfe_back import rfe_pkg::*; #(
	parameter int FRAME_WIDTH  = 240,
	parameter int FRAME_HEIGHT = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  rfe_cmd_t   head,
	input  fifo_stat_t stat,
	output logic       pop,
	output logic       init_busy,
	rfe_pix_if.source  pix
);

	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(FRAME_WIDTH);
	localparam int RW    = $clog2(FRAME_HEIGHT);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	back_state_t       st_q, st_d;
	logic [CW-1:0]     col_q, sx_q, ex_q;
	logic [RW-1:0]     row_q, ey_q;
	logic [AW-1:0]     row_base_q;
	logic [WORD_W-1:0] word_q;
	logic              zero_q;
	logic              init_q;
	logic              out_valid_q, out_zero_q;

	logic              last_pix, out_free, fin;
	logic              mem_we, mem_re, rd_fire;
	logic [AW-1:0]     addr;

	assign last_pix  = (col_q == ex_q) && (row_q == ey_q);
	assign out_free  = !out_valid_q || pix.ready;
	assign addr      = row_base_q + AW'(col_q);
	assign pop       = fin && !stat.empty;
	assign init_busy = init_q;

	// next state
	always_comb begin
		st_d = st_q;
		if (fin) begin
			if (!stat.empty) begin
				st_d = (head.op == OP_READ) ? BK_READ : BK_FILL;
			end else begin
				st_d = BK_IDLE;
			end
		end
	end

	// outputs
	always_comb begin
		fin     = 1'b0;
		mem_we  = 1'b0;
		rd_fire = 1'b0;
		case (st_q)
			BK_IDLE: begin
				fin = 1'b1;
			end
			BK_FILL: begin
				mem_we = 1'b1;
				fin    = last_pix;
			end
			BK_READ: begin
				rd_fire = out_free;
				fin     = out_free;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		mem_re = rd_fire && !zero_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= word_q;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	// sequencer; reset starts a zero sweep over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BK_FILL;
			col_q      <= '0;
			sx_q       <= '0;
			ex_q       <= CW'(FRAME_WIDTH - 1);
			row_q      <= '0;
			ey_q       <= RW'(FRAME_HEIGHT - 1);
			row_base_q <= '0;
			word_q     <= '0;
			zero_q     <= 1'b0;
			init_q     <= 1'b1;
		end else begin
			st_q <= st_d;
			if (st_q == BK_FILL && last_pix) begin
				init_q <= 1'b0;
			end
			if (pop) begin
				col_q      <= head.sx[CW-1:0];
				sx_q       <= head.sx[CW-1:0];
				ex_q       <= head.ex[CW-1:0];
				row_q      <= head.sy[RW-1:0];
				ey_q       <= head.ey[RW-1:0];
				row_base_q <= head.row_base[AW-1:0];
				word_q     <= head.word;
				zero_q     <= head.zero;
			end else if (st_q == BK_FILL) begin
				if (col_q == ex_q) begin
					col_q      <= sx_q;
					row_q      <= row_q + 1'b1;
					row_base_q <= row_base_q + AW'(FRAME_WIDTH);
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// result register; rdata_q only moves on a read, so it holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_zero_q  <= 1'b0;
		end else if (rd_fire) begin
			out_valid_q <= 1'b1;
			out_zero_q  <= zero_q;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.pixel_word = out_zero_q ? '0 : rdata_q;

	a_init_no_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> stat.empty)
		else $error("job queued during clearing pass");

	a_sweep_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_FILL |-> (col_q <= ex_q) && (row_q <= ey_q))
		else $error("sweep left its rectangle");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_fire |=> out_valid_q && (out_zero_q == $past(zero_q)))
		else $error("read did not present a result");

endmodule
